// ===== sv/p2da_pkg.sv =====
// shared constants and types for the decimal ascii frame block
package p2da_pkg;

  localparam int VAL_W      = 32;
  localparam int BYTE_W     = 7;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_DIGITS = 8;
  // scaled magnitude never exceeds 32768000, which fits in 25 bits and 8 digits
  localparam int MAG_W      = 25;
  localparam int NDIG       = 8;
  localparam int BCD_W      = NDIG * 4;
  localparam int SH_W       = $clog2(MAG_W);
  localparam int CNT_W      = $clog2(NDIG + 1);

  localparam logic [BYTE_W-1:0] ASC_HEAD  = 7'h40;  // @
  localparam logic [BYTE_W-1:0] ASC_SEP   = 7'h2C;  // ,
  localparam logic [BYTE_W-1:0] ASC_TAIL  = 7'h21;  // !
  localparam logic [BYTE_W-1:0] ASC_MINUS = 7'h2D;  // -
  localparam logic [BYTE_W-1:0] ASC_ZERO  = 7'h30;  // 0

  function automatic logic [63:0] dec_limit();
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      acc = acc * 64'd10;
    end
    return acc - 64'd1;
  endfunction

  localparam logic [63:0] DEC_LIMIT = dec_limit();

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [BCD_W-1:0] digits;
  } p2da_dec_t;

endpackage

// ===== sv/p2da_dec.sv =====
// scales one q16.16 value by 1000 and converts the magnitude to bcd one bit per cycle
module p2da_dec import p2da_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] value_i,
  output p2da_dec_t        res_o
);

  typedef enum logic [1:0] {C_IDLE, C_SAT, C_SHIFT} cstate_e;

  cstate_e          state_q;
  logic [MAG_W-1:0] mag_q;
  logic [BCD_W-1:0] bcd_q;
  logic             neg_q;
  logic [SH_W-1:0]  cnt_q;

  logic [VAL_W:0]   abs_w;
  logic [42:0]      prod_w;
  logic [MAG_W-1:0] scaled_w;
  logic             over_w;
  logic [BCD_W-1:0] adj_w;

  // magnitude in 33 bits so the most negative input stays exact
  assign abs_w  = value_i[VAL_W-1] ? ((VAL_W+1)'(0) - {1'b1, value_i}) : {1'b0, value_i};
  // x1000 = x1024 - x16 - x8
  assign prod_w = {abs_w, 10'b0} - {6'b0, abs_w, 4'b0} - {7'b0, abs_w, 3'b0};
  assign scaled_w = prod_w[FRAC_BITS +: MAG_W];
  assign over_w   = 64'(mag_q) > DEC_LIMIT;

  // double dabble: add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj_w[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                   : bcd_q[i*4 +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      mag_q   <= '0;
      bcd_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            mag_q   <= scaled_w;
            neg_q   <= value_i[VAL_W-1];
            state_q <= C_SAT;
          end
        end
        C_SAT: begin
          if (over_w) begin
            mag_q <= DEC_LIMIT[MAG_W-1:0];
          end
          bcd_q   <= '0;
          cnt_q   <= SH_W'(MAG_W - 1);
          state_q <= C_SHIFT;
        end
        C_SHIFT: begin
          bcd_q <= {adj_w[BCD_W-2:0], mag_q[MAG_W-1]};
          mag_q <= {mag_q[MAG_W-2:0], 1'b0};
          if (cnt_q == '0) begin
            state_q <= C_IDLE;
          end else begin
            cnt_q <= cnt_q - SH_W'(1);
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign res_o.done   = (state_q == C_IDLE);
  assign res_o.neg    = neg_q;
  assign res_o.digits = bcd_q;

endmodule

// ===== sv/pair_to_decimal_ascii_frame.sv =====
// top level: turns a pair of q16.16 values into the ascii frame @a,b!
//
// Input channel: in_valid_i / in_stall_o carry first_value_i and second_value_i,
// both signed q16.16. Each value is scaled by 1000 and truncated toward zero.
// Output channel: out_valid_o / out_stall_i carry one ascii byte per word
// (out_byte_o) and last_o, which is high on the closing '!'.
// A frame is '@', first number, ',', second number, '!': 5 to 21 words.
// Numbers have no leading zeros, a '-' when negative and not scaled to zero, and zero is "0".
// Two converters work side by side, one binary bit per cycle; '@' goes out
// while they run, and the digits of each number are taken once its converter
// is done. A nonzero number then drops its leading zero digits before its
// first digit goes out.
// One item is in flight at a time: in_stall_o stays high from acceptance
// until the '!' has been loaded into the output register.
// A stall on the output holds the current word; the frame resumes after it.
// Reset clears the sequencer and the output valid; no word is pending.
module pair_to_decimal_ascii_frame import p2da_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [VAL_W-1:0]  first_value_i,
  input  logic [VAL_W-1:0]  second_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_LOAD, S_ZERO, S_SIGN, S_SKIP, S_DIG, S_SEP, S_TAIL
  } state_e;

  state_e            state_q;
  logic              sel_q;
  logic [BCD_W-1:0]  num_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              last_q;

  logic      accept_w;
  logic      can_emit_w;
  logic      emit_w;
  p2da_dec_t dec1_w;
  p2da_dec_t dec2_w;
  p2da_dec_t cur_w;
  logic [3:0] top_w;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept_w   = in_valid_i && !in_stall_o;
  assign can_emit_w = !out_valid_q || !out_stall_i;
  assign cur_w      = sel_q ? dec2_w : dec1_w;
  assign top_w      = num_q[BCD_W-1 -: 4];
  // states that load a word into the output register
  assign emit_w     = (state_q == S_HEAD) || (state_q == S_ZERO) || (state_q == S_SIGN) ||
                      (state_q == S_DIG)  || (state_q == S_SEP)  || (state_q == S_TAIL);

  p2da_dec u_dec1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept_w),
    .value_i (first_value_i),
    .res_o   (dec1_w)
  );

  p2da_dec u_dec2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept_w),
    .value_i (second_value_i),
    .res_o   (dec2_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      num_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      if (can_emit_w) begin
        out_valid_q <= emit_w;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_w) begin
            sel_q   <= 1'b0;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_HEAD;
            last_q      <= 1'b0;
            state_q     <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cur_w.done) begin
            num_q <= cur_w.digits;
            cnt_q <= CNT_W'(NDIG);
            priority if (cur_w.digits == '0) begin
              state_q <= S_ZERO;
            end else if (cur_w.neg) begin
              state_q <= S_SIGN;
            end else begin
              state_q <= S_SKIP;
            end
          end
        end
        S_ZERO: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_ZERO;
            last_q      <= 1'b0;
            state_q     <= sel_q ? S_TAIL : S_SEP;
          end
        end
        S_SIGN: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_MINUS;
            last_q      <= 1'b0;
            state_q     <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zero digits; the number is nonzero so this ends
          if (top_w == 4'd0) begin
            num_q <= {num_q[BCD_W-5:0], 4'd0};
            cnt_q <= cnt_q - CNT_W'(1);
          end else begin
            state_q <= S_DIG;
          end
        end
        S_DIG: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_ZERO + BYTE_W'(top_w);
            last_q      <= 1'b0;
            num_q       <= {num_q[BCD_W-5:0], 4'd0};
            cnt_q       <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= sel_q ? S_TAIL : S_SEP;
            end
          end
        end
        S_SEP: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_SEP;
            last_q      <= 1'b0;
            sel_q       <= 1'b1;
            state_q     <= S_LOAD;
          end
        end
        S_TAIL: begin
          if (can_emit_w) begin
            out_byte_q  <= ASC_TAIL;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

// ===== bench/tb_pair_to_decimal_ascii_frame.sv =====
// self-checking testbench for the decimal ascii frame block
module tb_pair_to_decimal_ascii_frame import p2da_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PER_PHASE = 110;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } value_pair_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } frame_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [VAL_W-1:0]  first_value_i;
  logic [VAL_W-1:0]  second_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_o;

  value_pair_t pair_q[$];
  frame_byte_t frame_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        in_taken;
  int          cycle_cnt;
  int          err_cnt;
  int          pair_cnt;
  int          word_cnt;
  int          neg_cnt;
  int          zero_cnt;
  int          wide_cnt;

  pair_to_decimal_ascii_frame dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    first_value_i  = '0;
    second_value_i = '0;
    in_taken       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void push_char(logic [BYTE_W-1:0] ch, logic last);
    frame_byte_t fb;
    fb.ch   = ch;
    fb.last = last;
    frame_q.push_back(fb);
  endfunction

  // scale by 1000, truncate toward zero, cap at the largest MAX_DIGITS-digit value, then write out in decimal
  function automatic void push_decimal(logic [VAL_W-1:0] raw);
    logic        neg;
    logic [31:0] mag32;
    logic [63:0] mag;
    logic [63:0] cap;
    logic [3:0]  digs [0:19];
    int          n;
    neg   = raw[VAL_W-1];
    mag32 = neg ? (~raw + 32'd1) : raw;
    mag   = ({32'd0, mag32} * 64'd1000) >> FRAC_BITS;
    cap   = 64'd1;
    for (int i = 0; i < MAX_DIGITS && i < 19; i++) begin
      cap = cap * 64'd10;
    end
    cap = cap - 64'd1;
    if (mag > cap) begin
      mag = cap;
    end
    if (mag == 64'd0) begin
      zero_cnt++;
      push_char(ASC_ZERO, 1'b0);
      return;
    end
    if (neg) begin
      neg_cnt++;
      push_char(ASC_MINUS, 1'b0);
    end
    n = 0;
    while (mag > 64'd0) begin
      digs[n] = 4'(mag % 64'd10);
      mag     = mag / 64'd10;
      n++;
    end
    if (n >= 7) begin
      wide_cnt++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      push_char(ASC_ZERO + BYTE_W'(digs[i]), 1'b0);
    end
  endfunction

  function automatic void predict_frame(value_pair_t vp);
    pair_cnt++;
    push_char(ASC_HEAD, 1'b0);
    push_decimal(vp.first);
    push_char(ASC_SEP, 1'b0);
    push_decimal(vp.second);
    push_char(ASC_TAIL, 1'b1);
  endfunction

  // smallest raw value whose scaled magnitude reaches n
  function automatic logic [VAL_W-1:0] raw_for(longint n);
    return VAL_W'((n * 65536 + 999) / 1000);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    longint           p;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = VAL_W'($signed($urandom_range(400)) - 200);
      6: begin
        p = 1;
        for (int i = $urandom_range(7); i > 0; i--) begin
          p = p * 10;
        end
        v = raw_for(p) + VAL_W'($signed($urandom_range(140)) - 70);
      end
      7: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                               : 32'h7FFF_FFFF - $urandom_range(3);
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(9) == 0) begin
      v = ~v + 32'd1;
    end
    return v;
  endfunction

  function automatic void queue_pair(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    value_pair_t vp;
    vp.first  = a;
    vp.second = b;
    pair_q.push_back(vp);
  endfunction

  task automatic report(string what, int expv, int actv);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, expv, actv);
    end
  endtask

  // input side: valid only drops or moves on once the current word is taken
  always @(negedge clk_i) begin : drive_proc
    value_pair_t cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pair_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = pair_q.pop_front();
        in_valid_i     <= 1'b1;
        first_value_i  <= cur.first;
        second_value_i <= cur.second;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : monitor_proc
    value_pair_t vp;
    frame_byte_t fb;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      vp.first  = first_value_i;
      vp.second = second_value_i;
      predict_frame(vp);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      word_cnt++;
      if (frame_q.size() == 0) begin
        report("unexpected word", 0, int'(out_byte_o));
      end else begin
        fb = frame_q.pop_front();
        if (out_byte_o !== fb.ch) begin
          report("out_byte", int'(fb.ch), int'(out_byte_o));
        end
        if (last_o !== fb.last) begin
          report("last", int'(fb.last), int'(last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, frame_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain_inputs();
    while (pair_q.size() > 0 || in_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  initial begin : stim_proc
    longint p;
    cycle_cnt = 0;
    err_cnt   = 0;
    pair_cnt  = 0;
    word_cnt  = 0;
    neg_cnt   = 0;
    zero_cnt  = 0;
    wide_cnt  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero, tiny values that truncate to zero, extremes, digit count edges
    queue_pair(32'd0, 32'd0);
    queue_pair(32'hFFFF_FFFF, 32'd1);
    queue_pair(32'd65, -32'd65);
    queue_pair(32'd66, -32'd66);
    queue_pair(32'h7FFF_FFFF, 32'h8000_0000);
    queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
    queue_pair(32'h0001_0000, 32'hFFFF_0000);
    p = 10;
    for (int k = 1; k <= 7; k++) begin
      queue_pair(raw_for(p - 1), -raw_for(p));
      queue_pair(-raw_for(p - 1), raw_for(p));
      p = p * 10;
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        queue_pair(pick_value(), pick_value());
      end
      drain_inputs();
    end

    while (frame_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (frame_q.size() > 0) begin
      report("missing words", 0, frame_q.size());
    end

    $display("sent %0d value pairs under four idle/stall mixes, checked %0d frame words",
             pair_cnt, word_cnt);
    $display("numbers seen: %0d negative, %0d written as zero, %0d with seven or more digits",
             neg_cnt, zero_cnt, wide_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/p2da_pkg.sv
sv/p2da_dec.sv
sv/pair_to_decimal_ascii_frame.sv
bench/tb_pair_to_decimal_ascii_frame.sv
